// ===== sv/llsch_pkg.sv =====
// Shared types, sizes and codes for the least-laxity job scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package llsch_pkg;

  localparam int MAX_JOBS    = 64;
  localparam int MAX_WORKERS = 255;
  localparam int TIME_BITS   = 16;

  localparam int SLOT_W = $clog2(MAX_JOBS);
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int WRK_W  = $clog2(MAX_WORKERS + 1);
  localparam int DL_W   = 16;
  localparam int MEM_W  = 2 * DL_W;
  // key = deadline - remaining, wide enough to compare against the tick time
  localparam int CMP_W  = (TIME_BITS + 1 > DL_W + 1) ? TIME_BITS + 1 : DL_W + 1;

  localparam logic [1:0] FN_ARRIVE = 2'd0;
  localparam logic [1:0] FN_JOIN   = 2'd1;
  localparam logic [1:0] FN_LEAVE  = 2'd2;
  localparam logic [1:0] FN_TICK   = 2'd3;

  localparam logic [2:0] ST_ACCEPT  = 3'd0;
  localparam logic [2:0] ST_REJECT  = 3'd1;
  localparam logic [2:0] ST_PENDING = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_MISS    = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  job_id;
    logic [15:0] deadline;
    logic [15:0] work;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] now;
    logic [6:0]  served;
    logic [6:0]  pending;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SERVE,
    S_MISS,
    S_MDRAIN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic simple_op;   // arrive, join or leave, done at the accept edge
    logic tick_init;
    logic scan_issue;
    logic serve;
    logic miss_issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic no_workers;
    logic addr_last;
    logic found;
    logic more_workers;
  } stat_t;

endpackage

// ===== sv/llsch_ctrl.sv =====
// Sequencer for the scheduler: accepts words and steps a tick through its scans.
// Depends on llsch_pkg; drives the datapath by cmd_t and reads stat_t back.
module llsch_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        func,
  input  llsch_pkg::stat_t  stat,
  output logic              busy,
  output llsch_pkg::cmd_t   cmd
);
  import llsch_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && func == FN_TICK) begin
          state_nxt = stat.no_workers ? S_MISS : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.addr_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_SERVE;
      S_SERVE: begin
        // another pass only if this one found a job and workers remain
        state_nxt = (stat.found && stat.more_workers) ? S_SCAN : S_MISS;
      end
      S_MISS: begin
        if (stat.addr_last) begin
          state_nxt = S_MDRAIN;
        end
      end
      S_MDRAIN: state_nxt = S_FIN;
      S_FIN:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    busy           = (state_r != S_IDLE);
    cmd.simple_op  = accept && (func != FN_TICK);
    cmd.tick_init  = accept && (func == FN_TICK);
    cmd.scan_issue = (state_r == S_SCAN);
    cmd.serve      = (state_r == S_SERVE);
    cmd.miss_issue = (state_r == S_MISS);
    cmd.finish     = (state_r == S_FIN);
  end

endmodule

// ===== sv/llsch_dpath.sv =====
// Datapath: job memory, valid and served bits, minimum-key compare, counters.
// Depends on llsch_pkg; sequenced by llsch_ctrl through cmd_t.
module llsch_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  llsch_pkg::cmd_t      cmd,
  input  llsch_pkg::in_word_t  in_word,
  output llsch_pkg::stat_t     stat,
  output logic                 out_strobe,
  output llsch_pkg::out_word_t out_word
);
  import llsch_pkg::*;

  // job memory: {deadline, remaining} per slot
  logic [MEM_W-1:0]     mem [MAX_JOBS];
  logic [MEM_W-1:0]     rd_data_r;

  logic [MAX_JOBS-1:0]  valid_r;
  logic [MAX_JOBS-1:0]  srv_r;
  logic [CNT_W-1:0]     pending_r;
  logic [CNT_W-1:0]     nsrv_r;
  logic [WRK_W-1:0]     workers_r;
  logic [TIME_BITS-1:0] tick_r;
  logic                 missed_r;

  logic [SLOT_W-1:0]    addr_r;
  logic                 cmp_vld_r;
  logic                 cmp_miss_r;
  logic [SLOT_W-1:0]    cmp_slot_r;

  logic                 found_r;
  logic [SLOT_W-1:0]    best_r;
  logic signed [CMP_W-1:0] bkey_r;
  logic [DL_W-1:0]      best_dl_r;
  logic [DL_W-1:0]      best_rem_r;

  logic                 out_strobe_r;
  out_word_t            out_word_r;

  logic [SLOT_W-1:0]    arr_slot;
  logic                 arr_ok;
  logic                 is_arrive;
  logic [CNT_W-1:0]     pending_nxt;
  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_wa;
  logic [MEM_W-1:0]     mem_wd;
  logic [DL_W-1:0]      cmp_dl;
  logic [DL_W-1:0]      cmp_rem;
  logic signed [CMP_W-1:0] cmp_key;
  logic signed [CMP_W-1:0] tick_key;
  logic                 elig;
  logic                 miss_hit;
  logic [15:0]          now_cap;
  logic                 srv_write;

  assign arr_slot  = SLOT_W'(in_word.job_id);
  assign is_arrive = (in_word.func == FN_ARRIVE);
  assign arr_ok    = is_arrive && (32'(in_word.job_id) < MAX_JOBS) &&
                     (in_word.work != '0) && !valid_r[arr_slot];
  assign pending_nxt = arr_ok ? pending_r + CNT_W'(1) : pending_r;

  assign srv_write = cmd.serve && found_r;
  assign mem_we    = (cmd.simple_op && arr_ok) || srv_write;
  assign mem_wa    = srv_write ? best_r : arr_slot;
  assign mem_wd    = srv_write ? {best_dl_r, best_rem_r - DL_W'(1)}
                               : {in_word.deadline, in_word.work};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.scan_issue || cmd.miss_issue) begin
      rd_data_r <= mem[addr_r];
    end
  end

  assign cmp_dl   = rd_data_r[MEM_W-1 -: DL_W];
  assign cmp_rem  = rd_data_r[DL_W-1:0];
  assign cmp_key  = signed'(CMP_W'(cmp_dl)) - signed'(CMP_W'(cmp_rem));
  assign tick_key = signed'(CMP_W'(tick_r));
  assign elig     = cmp_vld_r && !cmp_miss_r && valid_r[cmp_slot_r] &&
                    !srv_r[cmp_slot_r];
  assign miss_hit = cmp_vld_r && cmp_miss_r && valid_r[cmp_slot_r] &&
                    (cmp_key <= tick_key);

  assign now_cap = (32'(tick_r) > 32'hFFFF) ? 16'hFFFF : 16'(tick_r);

  // scan address and compare pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      nsrv_r    <= '0;
    end else begin
      cmp_vld_r <= cmd.scan_issue || cmd.miss_issue;
      if (cmd.tick_init || cmd.serve) begin
        addr_r  <= '0;
        found_r <= 1'b0;
      end else if (cmd.scan_issue || cmd.miss_issue) begin
        addr_r <= addr_r + SLOT_W'(1);
      end
      if (elig && (!found_r || cmp_key < bkey_r)) begin
        found_r <= 1'b1;
      end
      if (cmd.tick_init) begin
        nsrv_r <= '0;
      end else if (srv_write) begin
        nsrv_r <= nsrv_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_miss_r <= cmd.miss_issue;
    cmp_slot_r <= addr_r;
    // strict compare in slot order keeps ties on the lower slot
    if (elig && (!found_r || cmp_key < bkey_r)) begin
      best_r     <= cmp_slot_r;
      bkey_r     <= cmp_key;
      best_dl_r  <= cmp_dl;
      best_rem_r <= cmp_rem;
    end
  end

  // job table bits and scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      srv_r     <= '0;
      pending_r <= '0;
      workers_r <= '0;
      tick_r    <= '0;
      missed_r  <= 1'b0;
    end else begin
      if (cmd.simple_op) begin
        pending_r <= pending_nxt;
        if (arr_ok) begin
          valid_r[arr_slot] <= 1'b1;
        end
        if (in_word.func == FN_JOIN && 32'(workers_r) < MAX_WORKERS) begin
          workers_r <= workers_r + WRK_W'(1);
        end
        if (in_word.func == FN_LEAVE && workers_r != '0) begin
          workers_r <= workers_r - WRK_W'(1);
        end
      end
      if (srv_write) begin
        srv_r[best_r] <= 1'b1;
        // free the slot when its last unit of work is done
        if (best_rem_r == DL_W'(1)) begin
          valid_r[best_r] <= 1'b0;
          pending_r       <= pending_r - CNT_W'(1);
        end
      end
      if (miss_hit) begin
        missed_r <= 1'b1;
      end
      if (cmd.finish) begin
        srv_r <= '0;
        if (tick_r != '1) begin
          tick_r <= tick_r + TIME_BITS'(1);
        end
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.simple_op || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.simple_op) begin
      out_word_r.status  <= (is_arrive && !arr_ok) ? ST_REJECT : ST_ACCEPT;
      out_word_r.now     <= now_cap;
      out_word_r.served  <= '0;
      out_word_r.pending <= 7'(pending_nxt);
    end else if (cmd.finish) begin
      priority if (missed_r) begin
        out_word_r.status <= ST_MISS;
      end else if (pending_r == '0) begin
        out_word_r.status <= ST_EMPTY;
      end else begin
        out_word_r.status <= ST_PENDING;
      end
      out_word_r.now     <= now_cap;
      out_word_r.served  <= 7'(nsrv_r);
      out_word_r.pending <= 7'(pending_r);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  always_comb begin
    stat              = '0;
    stat.no_workers   = (workers_r == '0);
    stat.addr_last    = (addr_r == SLOT_W'(MAX_JOBS - 1));
    stat.found        = found_r;
    stat.more_workers = (32'(nsrv_r) + 32'd1 < 32'(workers_r));
  end

endmodule

// ===== sv/least_laxity_job_scheduler_top.sv =====
// Top level of the least-laxity job scheduler: controller plus datapath.
// Depends on llsch_pkg, llsch_ctrl and llsch_dpath.
//
// A word is taken when start is high and busy is low; every word gives
// exactly one result word, shown on out_word for one cycle under out_strobe,
// and the receiver cannot stall it. Arrive, join and leave words finish at
// the accept edge: busy stays low and the result appears on the next cycle.
// A tick runs one pass over the job table for each job it serves, plus one
// pass that comes up empty when jobs run out before workers, plus a final
// deadline-miss pass; each pass reads every slot in turn through the single
// read port of the job memory, busy stays high for the whole tick, and its
// result shows in the same cycle that busy drops.
module least_laxity_job_scheduler_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  llsch_pkg::in_word_t  in_word,
  output logic                 out_strobe,
  output llsch_pkg::out_word_t out_word
);
  import llsch_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  llsch_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_word.func),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  llsch_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_word    (in_word),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

`ifndef SYNTH
  // a result never shows while a tick is still in progress
  a_no_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // arrive, join and leave answer on the very next cycle
  a_simple_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.func != FN_TICK) |=> out_strobe)
    else $error("missing result for non-tick word");

  // only ticks serve jobs
  a_served_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_word.status == ST_ACCEPT || out_word.status == ST_REJECT))
      |-> out_word.served == '0)
    else $error("served count on non-tick result");

  // the pending count never exceeds the table size
  a_pending_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> 32'(out_word.pending) <= MAX_JOBS)
    else $error("pending count beyond table size");
`endif

endmodule
